// ----- design/saes64_pkg.sv -----
// Shared types, constants and nibble functions for the small-scale
// 64-bit block cipher pipeline. No dependencies.
`default_nettype none

package saes64_pkg;

    localparam int BLK_W      = 64;
    localparam int NIB_W      = 4;
    localparam int NUM_NIBS   = BLK_W / NIB_W;
    localparam int ROUND_CNT  = 4;
    localparam int KEY_CNT    = ROUND_CNT + 1;
    localparam int KIDX_W     = 3;

    // Field polynomial x^4+x+1, low bits after reduction
    localparam logic [NIB_W-1:0] GF_POLY = 4'h3;

    typedef logic [BLK_W-1:0]  t_blk;
    typedef logic [NIB_W-1:0]  t_nib;
    typedef logic [KIDX_W-1:0] t_kidx;
    typedef t_blk [KEY_CNT-1:0] t_keys;

    // Register indexes of the key port
    typedef enum logic [KIDX_W-1:0] {
        KEY_WHITEN = 3'd0,
        KEY_RND1   = 3'd1,
        KEY_RND2   = 3'd2,
        KEY_RND3   = 3'd3,
        KEY_FINAL  = 3'd4
    } t_key_sel;

    function automatic t_nib sbox(input t_nib x);
        t_nib y;
        unique case (x)
            4'h0: y = 4'h6;
            4'h1: y = 4'hB;
            4'h2: y = 4'h5;
            4'h3: y = 4'h4;
            4'h4: y = 4'h2;
            4'h5: y = 4'hE;
            4'h6: y = 4'h7;
            4'h7: y = 4'hA;
            4'h8: y = 4'h9;
            4'h9: y = 4'hD;
            4'hA: y = 4'hF;
            4'hB: y = 4'hC;
            4'hC: y = 4'h3;
            4'hD: y = 4'h1;
            4'hE: y = 4'h0;
            4'hF: y = 4'h8;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    // Multiply by 2 in GF(2^4)
    function automatic t_nib xtime(input t_nib x);
        return {x[2:0], 1'b0} ^ (x[3] ? GF_POLY : 4'h0);
    endfunction

    // Multiply by 3 in GF(2^4)
    function automatic t_nib mul3(input t_nib x);
        return xtime(x) ^ x;
    endfunction

endpackage

`default_nettype wire

// ----- design/small_aes_64bit_encrypt.sv -----
// Top level: key registers, whitening stage and four round stages.
// Depends on saes64_pkg, saes64_keys, saes64_round.
//
//  channel   direction  handshake                 payload
//  s (in)    slave      i_s_tvalid / o_s_tready   i_s_tdata  = plaintext
//  m (out)   master     o_m_tvalid / i_m_tready   o_m_tdata  = ciphertext
//  cfg       write      i_cfg_we                  i_cfg_idx, i_cfg_data = key
//
// One block per cycle while the output beat is not stalled; a block passes
// the whitening register and one register per round, the last being the output register.
// All stages advance together; while the output beat waits, the whole
// pipeline holds, otherwise empty stages fill.
// Reset (synchronous, active low) clears the stage valid bits and the keys.
`default_nettype none

module small_aes_64bit_encrypt (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  saes64_pkg::t_blk    i_s_tdata,   // [63:0] plaintext
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output saes64_pkg::t_blk    o_m_tdata,   // [63:0] ciphertext
    input  wire                 i_cfg_we,
    input  saes64_pkg::t_kidx   i_cfg_idx,
    input  saes64_pkg::t_blk    i_cfg_data
);
    import saes64_pkg::*;

    t_keys w_keys;
    logic  w_en;
    logic  r_wvalid;
    t_blk  r_wblk;
    logic  w_valid [ROUND_CNT+1];
    t_blk  w_blk   [ROUND_CNT+1];

    saes64_keys u_keys (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_keys     (w_keys)
    );

    // Pipeline advances unless the output beat is stalled
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // Whitening stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= 1'b0;
        end else if (w_en) begin
            r_wvalid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wblk <= i_s_tdata ^ w_keys[0];
        end
    end

    assign w_valid[0] = r_wvalid;
    assign w_blk[0]   = r_wblk;

    // Round stages; the final one skips MixColumns
    for (genvar g = 1; g <= ROUND_CNT; g++) begin : g_round
        saes64_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_mix   (g != ROUND_CNT),
            .i_valid (w_valid[g-1]),
            .i_blk   (w_blk[g-1]),
            .i_key   (w_keys[g]),
            .o_valid (w_valid[g]),
            .o_blk   (w_blk[g])
        );
    end

    assign o_m_tvalid = w_valid[ROUND_CNT];
    assign o_m_tdata  = w_blk[ROUND_CNT];

`ifndef SYNTHESIS
    // A held pipeline keeps every stage's valid bit
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_wvalid) && $stable(w_valid[1]) && $stable(w_valid[2])
                   && $stable(w_valid[3]) && $stable(o_m_tvalid)))
        else $error("stage valid changed while stalled");

    // An accepted beat reaches the whitening stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_wvalid && r_wblk == ($past(i_s_tdata)
                                        ^ $past(w_keys[0]))))
        else $error("accepted beat not captured");

    // Reset empties the output stage
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A final-key write lands in the register file
    a_key_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == KEY_FINAL) |=> w_keys[4] == $past(i_cfg_data))
        else $error("final key write lost");
`endif

endmodule

`default_nettype wire

// ----- design/saes64_keys.sv -----
// Round key register file, written through the plain configuration port.
// Depends on saes64_pkg.
`default_nettype none

module saes64_keys (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  saes64_pkg::t_kidx   i_cfg_idx,
    input  saes64_pkg::t_blk    i_cfg_data,
    output saes64_pkg::t_keys   o_keys
);
    import saes64_pkg::*;

    t_keys r_keys;
    t_keys n_keys;

    // Decode the write; indexes past the last key are dropped
    always_comb begin
        n_keys = r_keys;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                KEY_WHITEN: n_keys[0] = i_cfg_data;
                KEY_RND1:   n_keys[1] = i_cfg_data;
                KEY_RND2:   n_keys[2] = i_cfg_data;
                KEY_RND3:   n_keys[3] = i_cfg_data;
                KEY_FINAL:  n_keys[4] = i_cfg_data;
                default:    n_keys = r_keys;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else begin
            r_keys <= n_keys;
        end
    end

    assign o_keys = r_keys;

endmodule

`default_nettype wire

// ----- design/saes64_round.sv -----
// One cipher round as a pipeline stage: S-box, ShiftRows, optional
// MixColumns, key add, then the stage register. Depends on saes64_pkg.
`default_nettype none

module saes64_round (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_mix,
    input  wire                 i_valid,
    input  saes64_pkg::t_blk    i_blk,
    input  saes64_pkg::t_blk    i_key,
    output logic                o_valid,
    output saes64_pkg::t_blk    o_blk
);
    import saes64_pkg::*;

    logic r_valid;
    t_blk r_blk;
    t_blk n_blk;
    t_nib sub [NUM_NIBS];
    t_nib mix [NUM_NIBS];
    t_blk w_pre;

    // S-box with ShiftRows folded in: row r rotated left by r
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                sub[r*4 + c] = sbox(i_blk[NIB_W*(r*4 + ((c + r) % 4)) +: NIB_W]);
            end
        end
    end

    // MixColumns, circulant (2,3,1,1)
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                mix[r*4 + c] = xtime(sub[((r + 0) % 4)*4 + c])
                             ^ mul3(sub[((r + 1) % 4)*4 + c])
                             ^ sub[((r + 2) % 4)*4 + c]
                             ^ sub[((r + 3) % 4)*4 + c];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_NIBS; i++) begin
            w_pre[NIB_W*i +: NIB_W] = i_mix ? mix[i] : sub[i];
        end
        n_blk = w_pre ^ i_key;
    end

    // Stage register; valid cleared by reset, data held when stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

`default_nettype wire
